>>> rtl/dsrs_pkg.sv
// Shared types and constants for the dense set with random sampling.
// No dependencies; every other file in rtl/ imports this package.
package dsrs_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VALUE_W = 32;
	localparam int RND_W = 16;
	localparam int STEP_W = $clog2(RND_W);
	localparam int COUNT_OUT_W = 7;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;
	localparam logic [1:0] STATUS_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]                req_type;
		logic signed [VALUE_W-1:0] value;
		logic [RND_W-1:0]          random_word;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] sample_value;
		logic [COUNT_OUT_W-1:0]    member_count;
	} result_t;

	// Access command from the sequencer to the member store.
	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [VALUE_W-1:0] wr_data;
	} mem_cmd_t;

	// Start command for the modulo unit.
	typedef struct packed {
		logic             go;
		logic [RND_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} mod_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MOVE,
		ST_MOD,
		ST_SAMPLE
	} state_t;

endpackage

>>> rtl/dense_set_random_sample_core.sv
// Top level of the dense set with random sampling: request sequencer,
// member count and result register. Depends on dsrs_pkg, dsrs_store, dsrs_mod.
//
//  channel   ports                    transfer when
//  request   start, busy, req         start high and busy low at a rising edge
//  result    done, result             done high (one cycle, cannot be held off)
//
// Insert and remove scan the live entries through the store's read port, one
// entry per cycle, until a hit or the end of the live entries; a remove that
// hits an entry other than the last then moves the last entry into its place.
// Sample starts the modulo unit, reads the store at the remainder on its done
// strobe, then registers the read value. The result strobe comes in the first
// cycle with busy low again; reset empties the set at once, and the store itself is never cleared.
module dense_set_random_sample_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsrs_pkg::req_t    req,
	output logic              done,
	output dsrs_pkg::result_t result
);
	import dsrs_pkg::*;

	state_t             state_q;
	state_t             state_d;
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   last_full;
	logic [ADDR_W-1:0]  last;
	logic [ADDR_W-1:0]  pos_q;
	logic               cmp_valid_s1;
	logic [ADDR_W-1:0]  cmp_idx_s1;
	logic [VALUE_W-1:0] rdata;
	logic               accept;
	logic               hit;
	logic               issue;
	logic               miss;
	mem_cmd_t           mem_cmd;
	mod_cmd_t           mod_cmd;
	logic               mod_done;
	logic [ADDR_W-1:0]  mod_rem;
	logic               finish;
	logic [1:0]         fin_status;
	logic [VALUE_W-1:0] fin_sample;
	logic               cnt_inc;
	logic               cnt_dec;
	result_t            result_q;
	logic               done_q;

	dsrs_store u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (rdata)
	);

	dsrs_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mod_cmd),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign last_full = count_q - CNT_W'(1);
	assign last = last_full[ADDR_W-1:0];

	// Search pipeline: a read issued this cycle is compared the next one.
	assign hit = cmp_valid_s1 && (rdata == $unsigned(req_q.value));
	assign issue = !hit && (idx_q < count_q);
	assign miss = !hit && !issue && !cmp_valid_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_INSERT || req.req_type == REQ_REMOVE) begin
						state_d = ST_SEARCH;
					end else if (req.req_type == REQ_SAMPLE && count_q != '0) begin
						state_d = ST_MOD;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					if (req_q.req_type == REQ_REMOVE && cmp_idx_s1 != last) begin
						state_d = ST_MOVE;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (miss) begin
					state_d = ST_IDLE;
				end
			end
			ST_MOVE: state_d = ST_IDLE;
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_SAMPLE;
				end
			end
			ST_SAMPLE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_cmd = '0;
		mod_cmd = '0;
		finish = 1'b0;
		fin_status = STATUS_DONE;
		fin_sample = '0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		mod_cmd.dividend = req.random_word;
		mod_cmd.divisor = count_q;
		mem_cmd.wr_data = $unsigned(req_q.value);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_SAMPLE) begin
						if (count_q == '0) begin
							finish = 1'b1;
							fin_status = STATUS_EMPTY;
						end else begin
							mod_cmd.go = 1'b1;
						end
					end else if (req.req_type != REQ_INSERT && req.req_type != REQ_REMOVE) begin
						// Unused request code: no change, plain done.
						finish = 1'b1;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					if (req_q.req_type == REQ_INSERT) begin
						finish = 1'b1;
						fin_status = STATUS_MISS;
					end else if (cmp_idx_s1 != last) begin
						mem_cmd.rd_en = 1'b1;
						mem_cmd.rd_addr = last;
					end else begin
						finish = 1'b1;
						cnt_dec = 1'b1;
					end
				end else if (issue) begin
					mem_cmd.rd_en = 1'b1;
					mem_cmd.rd_addr = idx_q[ADDR_W-1:0];
				end else if (miss) begin
					finish = 1'b1;
					if (req_q.req_type == REQ_REMOVE) begin
						fin_status = STATUS_MISS;
					end else if (count_q == CAP_COUNT) begin
						fin_status = STATUS_FULL;
					end else begin
						mem_cmd.wr_en = 1'b1;
						mem_cmd.wr_addr = count_q[ADDR_W-1:0];
						cnt_inc = 1'b1;
					end
				end
			end
			ST_MOVE: begin
				// Last entry fills the hole left by the removed one.
				mem_cmd.wr_en = 1'b1;
				mem_cmd.wr_addr = pos_q;
				mem_cmd.wr_data = rdata;
				cnt_dec = 1'b1;
				finish = 1'b1;
			end
			ST_MOD: begin
				if (mod_done) begin
					mem_cmd.rd_en = 1'b1;
					mem_cmd.rd_addr = mod_rem;
				end
			end
			ST_SAMPLE: begin
				finish = 1'b1;
				fin_sample = rdata;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (cnt_inc) begin
			count_d = count_q + CNT_W'(1);
		end else if (cnt_dec) begin
			count_d = last_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			cmp_valid_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q <= finish;
			if (accept) begin
				idx_q <= '0;
				cmp_valid_s1 <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				cmp_valid_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end else begin
				cmp_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		cmp_idx_s1 <= idx_q[ADDR_W-1:0];
		if (hit) begin
			pos_q <= cmp_idx_s1;
		end
		if (finish) begin
			result_q.status <= fin_status;
			result_q.sample_value <= $signed(fin_sample);
			result_q.member_count <= COUNT_OUT_W'(count_d);
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

>>> rtl/dsrs_store.sv
// Member store: one write port and one read port, read data registered.
// Depends on dsrs_pkg.
module dsrs_store (
	input  logic                          clk,
	input  dsrs_pkg::mem_cmd_t            cmd,
	output logic [dsrs_pkg::VALUE_W-1:0]  rdata
);
	import dsrs_pkg::*;

	logic [VALUE_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata <= mem[cmd.rd_addr];
		end
	end

endmodule

>>> rtl/dsrs_mod.sv
// Bit-serial restoring modulo: one dividend bit per cycle.
// Depends on dsrs_pkg.
module dsrs_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsrs_pkg::mod_cmd_t          cmd,
	output logic                        done,
	output logic [dsrs_pkg::ADDR_W-1:0] remainder
);
	import dsrs_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0] dvd_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q, dvd_q[RND_W-1]};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(RND_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			dvd_q <= cmd.dividend;
			div_q <= cmd.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			// The partial remainder stays below the divisor, so it fits CNT_W bits.
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign remainder = rem_q[ADDR_W-1:0];

endmodule
